@@ rtl/core/jhs_pkg.sv @@
// Package for the JPEG 2000 header scanner: word types, parse phases,
// status codes and the signature and marker constants.
// No dependencies.
package jhs_pkg;

	// Input word: one buffer byte and its end mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_t;

	// Result word: status and the SIZ fields
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [23:0] total_depth;
	} out_t;

	typedef enum logic [2:0] {
		PH_SIG    = 3'd0,
		PH_BOXHDR = 3'd1,
		PH_SKIP   = 3'd2,
		PH_CSHDR  = 3'd3,
		PH_COMP   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		V_UNDECIDED = 2'd0,
		V_NOTJP2    = 2'd1,
		V_ERROR     = 2'd2
	} verdict_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOTJP2 = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	localparam logic [31:0] J2K_MAGIC   = 32'hff4f_ff51;
	localparam logic [31:0] SIG_HEAD    = 32'h0000_000c;
	localparam logic [63:0] SIG_TAIL    = 64'h6a50_2020_0d0a_870a;
	localparam logic [31:0] TYPE_JP2C   = 32'h6a70_3263;
	localparam logic [15:0] SIZ_MIN_LEN = 16'd38;
	localparam logic [31:0] BOX_HDR_LEN = 32'd8;

	// Byte positions inside the signature, box header and SIZ header
	localparam int POS_MAGIC_END  = 3;
	localparam int POS_SIG_END    = 11;
	localparam int POS_BOXHDR_END = 7;
	localparam int POS_LSIZ_END   = 5;
	localparam int POS_WIDTH_END  = 11;
	localparam int POS_HEIGHT_END = 15;
	localparam int POS_SIZ_LAST   = 41;

endpackage

@@ rtl/core/jpeg2000_header_scanner_core.sv @@
// JPEG 2000 header scanner: JP2 box walk and SIZ marker parse, one byte a cycle.
// Path: an accepted word is registered in s1, then parsed into the parse state; the
// result word (only on the end-of-buffer byte) is built from that parse and registered.
// Throughput: one byte per cycle; the input stage stalls only while a result waits.
// Reset: arst_n clears all parse state; the scanner also returns to reset
// state after every end-of-buffer byte, ready for the next buffer.
module jpeg2000_header_scanner_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jhs_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output jhs_pkg::out_t   out_data
);

	// Input register
	logic         valid_s1;
	jhs_pkg::in_t data_s1;
	logic         advance;

	// Parse state
	jhs_pkg::phase_t   phase_q, phase_d;
	jhs_pkg::verdict_t verdict_q, verdict_d;
	logic [COUNT_WIDTH-1:0] pos_q, pos_d;
	logic [31:0] left_q, left_d;
	logic [63:0] shift_q, shift_d;
	logic [15:0] comp_cnt_q, comp_cnt_d;
	logic [23:0] depth_q, depth_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [1:0]  triple_q, triple_d;

	// Result register
	logic          out_valid_q;
	jhs_pkg::out_t out_q;
	jhs_pkg::out_t result;

	logic [31:0] low32;
	logic [31:0] box_len;
	logic [31:0] left_dec;
	logic [COUNT_WIDTH-1:0] pos_inc;

	// Move s1 into the parser whenever the result slot is free
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Next parse state for the byte in s1
	always_comb begin
		shift_d    = {shift_q[55:0], data_s1.data_byte};
		low32      = shift_d[31:0];
		box_len    = shift_d[63:32];
		left_dec   = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
		pos_inc    = (pos_q != {COUNT_WIDTH{1'b1}}) ? pos_q + 1'b1 : pos_q;
		phase_d    = phase_q;
		verdict_d  = verdict_q;
		pos_d      = pos_q;
		left_d     = left_q;
		comp_cnt_d = comp_cnt_q;
		depth_d    = depth_q;
		width_d    = width_q;
		height_d   = height_q;
		triple_d   = triple_q;

		unique case (phase_q)
			jhs_pkg::PH_SIG: begin
				if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END)) begin
					if (low32 == jhs_pkg::J2K_MAGIC) begin
						phase_d = jhs_pkg::PH_CSHDR;
						left_d  = 32'd0;
						pos_d   = COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END + 1);
					end else if (low32 != jhs_pkg::SIG_HEAD) begin
						verdict_d = jhs_pkg::V_NOTJP2;
						phase_d   = jhs_pkg::PH_DONE;
					end else begin
						pos_d = pos_inc;
					end
				end else if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_SIG_END)) begin
					if (shift_d == jhs_pkg::SIG_TAIL) begin
						phase_d = jhs_pkg::PH_BOXHDR;
						pos_d   = '0;
					end else begin
						verdict_d = jhs_pkg::V_NOTJP2;
						phase_d   = jhs_pkg::PH_DONE;
					end
				end else begin
					pos_d = pos_inc;
				end
			end
			jhs_pkg::PH_BOXHDR: begin
				if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_BOXHDR_END)) begin
					pos_d = '0;
					if (low32 == jhs_pkg::TYPE_JP2C) begin
						left_d  = (box_len > jhs_pkg::BOX_HDR_LEN) ?
							box_len - jhs_pkg::BOX_HDR_LEN : 32'd0;
						phase_d = jhs_pkg::PH_CSHDR;
					end else if (box_len < jhs_pkg::BOX_HDR_LEN) begin
						verdict_d = jhs_pkg::V_ERROR;
						phase_d   = jhs_pkg::PH_DONE;
					end else begin
						left_d  = box_len - jhs_pkg::BOX_HDR_LEN;
						phase_d = (box_len != jhs_pkg::BOX_HDR_LEN) ?
							jhs_pkg::PH_SKIP : jhs_pkg::PH_BOXHDR;
					end
				end else begin
					pos_d = pos_inc;
				end
			end
			jhs_pkg::PH_SKIP: begin
				left_d = left_dec;
				if (left_dec == 32'd0) begin
					phase_d = jhs_pkg::PH_BOXHDR;
					pos_d   = '0;
				end
			end
			jhs_pkg::PH_CSHDR: begin
				left_d = left_dec;
				if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END) &&
						low32 != jhs_pkg::J2K_MAGIC) begin
					verdict_d = jhs_pkg::V_ERROR;
					phase_d   = jhs_pkg::PH_DONE;
				end else if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_LSIZ_END) &&
						low32[15:0] < jhs_pkg::SIZ_MIN_LEN) begin
					verdict_d = jhs_pkg::V_ERROR;
					phase_d   = jhs_pkg::PH_DONE;
				end else begin
					if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_WIDTH_END)) begin
						width_d = low32;
					end
					if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_HEIGHT_END)) begin
						height_d = low32;
					end
					if (pos_q == COUNT_WIDTH'(jhs_pkg::POS_SIZ_LAST)) begin
						comp_cnt_d = low32[15:0];
						depth_d    = 24'd0;
						triple_d   = 2'd0;
						phase_d    = jhs_pkg::PH_COMP;
					end
					pos_d = pos_inc;
				end
			end
			jhs_pkg::PH_COMP: begin
				left_d = left_dec;
				// Take the depth byte of each component triple
				if (comp_cnt_q != 16'd0) begin
					if (triple_q == 2'd0) begin
						depth_d = depth_q + 24'(data_s1.data_byte) + 24'd1;
					end
					if (triple_q == 2'd2) begin
						triple_d   = 2'd0;
						comp_cnt_d = comp_cnt_q - 16'd1;
					end else begin
						triple_d = triple_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Build the result word from the updated state
	always_comb begin
		result = '0;
		priority if (verdict_d == jhs_pkg::V_NOTJP2) begin
			result.status = jhs_pkg::ST_NOTJP2;
		end else if (verdict_d == jhs_pkg::V_ERROR) begin
			result.status = jhs_pkg::ST_ERROR;
		end else if (phase_d == jhs_pkg::PH_SIG) begin
			result.status = jhs_pkg::ST_NOTJP2;
		end else if (phase_d == jhs_pkg::PH_COMP && comp_cnt_d == 16'd0 &&
				left_d == 32'd0) begin
			result.status       = jhs_pkg::ST_OK;
			result.image_width  = width_d;
			result.image_height = height_d;
			result.total_depth  = depth_d;
		end else begin
			result.status = jhs_pkg::ST_ERROR;
		end
	end

	// Update parse state; drop back to reset state after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= jhs_pkg::PH_SIG;
			verdict_q  <= jhs_pkg::V_UNDECIDED;
			pos_q      <= '0;
			left_q     <= '0;
			shift_q    <= '0;
			comp_cnt_q <= '0;
			depth_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			triple_q   <= '0;
		end else if (valid_s1 && advance) begin
			if (data_s1.end_of_buffer) begin
				phase_q    <= jhs_pkg::PH_SIG;
				verdict_q  <= jhs_pkg::V_UNDECIDED;
				pos_q      <= '0;
				left_q     <= '0;
				shift_q    <= '0;
				comp_cnt_q <= '0;
				depth_q    <= '0;
				width_q    <= '0;
				height_q   <= '0;
				triple_q   <= '0;
			end else begin
				phase_q    <= phase_d;
				verdict_q  <= verdict_d;
				pos_q      <= pos_d;
				left_q     <= left_d;
				shift_q    <= shift_d;
				comp_cnt_q <= comp_cnt_d;
				depth_q    <= depth_d;
				width_q    <= width_d;
				height_q   <= height_d;
				triple_q   <= triple_d;
			end
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && data_s1.end_of_buffer;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && data_s1.end_of_buffer) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/jhs_checker.sv @@
// Port checker for the JPEG 2000 header scanner, bound to the top level.
// Depends on jhs_pkg and jpeg2000_header_scanner_core.
module jhs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input jhs_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input jhs_pkg::out_t out_data
);

	// A stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Fields are zero unless the status is ok
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != jhs_pkg::ST_OK |->
			out_data.image_width == 32'd0 && out_data.image_height == 32'd0 &&
			out_data.total_depth == 24'd0)
		else $error("fields set on a failed status");

	// Status is one of the three codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == jhs_pkg::ST_OK ||
			out_data.status == jhs_pkg::ST_NOTJP2 ||
			out_data.status == jhs_pkg::ST_ERROR)
		else $error("status code out of range");

	// A fresh result follows an accepted end-of-buffer word through the s1 and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.end_of_buffer, 2))
		else $error("result word without an end-of-buffer word");

	// Input stalls only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while result slot free");

endmodule

bind jpeg2000_header_scanner_core jhs_checker u_jhs_checker (.*);

@@ sim/jpeg2000_header_scanner_core_tb.sv @@
// Testbench for jpeg2000_header_scanner_core: drives whole buffers (raw codestreams,
// JP2 containers, noise) a byte word at a time and checks every status word.
// Depends on jhs_pkg and the scanner RTL.
module jpeg2000_header_scanner_core_tb;

	localparam int COUNT_WIDTH = 32;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_BUFFERS = 6;
	localparam int CS_HEAD_BYTES = jhs_pkg::POS_SIZ_LAST + 1;
	localparam int NUM_DIRECTED = 22;

	// Buffer layouts and the ways a jp2c box can state its length
	typedef enum logic [1:0] {
		LAY_NOISE,
		LAY_RAW,
		LAY_JP2
	} layout_t;

	typedef enum logic [2:0] {
		JL_NONE,
		JL_ZERO,
		JL_TINY,
		JL_EXACT,
		JL_HUGE
	} jp2c_len_t;

	// Recipe for one buffer; typed rows carry the status word to expect
	typedef struct packed {
		layout_t       layout;
		int            noise_len;
		int            boxes;
		logic [31:0]   box_len;
		jp2c_len_t     jlen;
		logic [15:0]   lsiz;
		logic [31:0]   width;
		logic [31:0]   height;
		logic [15:0]   csiz;
		int            depth;
		int            cut;
		int            extra;
		int            corrupt_at;
		logic          typed;
		jhs_pkg::out_t report;
	} buffer_plan_t;

	localparam jhs_pkg::out_t NO_REPORT = '0;
	localparam jhs_pkg::out_t NOTJP2_REPORT = '{jhs_pkg::ST_NOTJP2, 32'd0, 32'd0, 24'd0};
	localparam jhs_pkg::out_t ERROR_REPORT = '{jhs_pkg::ST_ERROR, 32'd0, 32'd0, 24'd0};

	// Directed buffers: short and broken signatures, SIZ extremes, box walk corner cases
	localparam buffer_plan_t DIRECTED_BUFFERS [NUM_DIRECTED] = '{
		'{LAY_NOISE, 1, 0, 32'd0, JL_NONE, 16'd0, 32'd0, 32'd0, 16'd0, 0,
			0, 0, -1, 1'b1, NOTJP2_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 7,
			41, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 7,
			38, 0, 0, 1'b1, NOTJP2_REPORT},
		'{LAY_JP2, 0, 0, 32'd0, JL_NONE, 16'd38, 32'd5, 32'd5, 16'd0, 0,
			0, 0, 3, 1'b1, NOTJP2_REPORT},
		'{LAY_JP2, 0, 0, 32'd0, JL_NONE, 16'd38, 32'd5, 32'd5, 16'd0, 0,
			0, 0, 9, 1'b1, NOTJP2_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd41, 32'hffff_ffff, 32'd0, 16'd1, 255,
			0, 0, -1, 1'b1, '{jhs_pkg::ST_OK, 32'hffff_ffff, 32'd0, 24'd256}},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd38, 32'd0, 32'hffff_ffff, 16'd0, 0,
			0, 0, -1, 1'b1, '{jhs_pkg::ST_OK, 32'd0, 32'hffff_ffff, 24'd0}},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd37, 32'd3, 32'd3, 16'd0, 0,
			30, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd0, 32'd3, 32'd3, 16'd0, 0,
			30, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'hffff, 32'd9, 32'd9, 16'hffff, 255,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd47, 32'd9, 32'd9, 16'd3, 0,
			1, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_RAW, 0, 0, 32'd0, JL_NONE, 16'd44, 32'd640, 32'd480, 16'd2, -1,
			0, 5, -1, 1'b0, NO_REPORT},
		'{LAY_JP2, 0, 1, 32'd8, JL_ZERO, 16'd44, 32'd17, 32'd33, 16'd2, 0,
			0, 0, -1, 1'b0, NO_REPORT},
		'{LAY_JP2, 0, 1, 32'd7, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 3,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 1, 32'd0, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 3,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 1, 32'd12, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 3,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 0, 32'd0, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 3,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 1, 32'hffff_ffff, JL_NONE, 16'd41, 32'd1, 32'd1, 16'd1, 3,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 2, 32'd16, JL_EXACT, 16'd47, 32'd1920, 32'd1080, 16'd3, 128,
			0, 0, -1, 1'b0, NO_REPORT},
		'{LAY_JP2, 0, 0, 32'd0, JL_HUGE, 16'd41, 32'd8, 32'd8, 16'd1, 11,
			0, 0, -1, 1'b1, ERROR_REPORT},
		'{LAY_JP2, 0, 0, 32'd0, JL_TINY, 16'd41, 32'd8, 32'd8, 16'd1, 11,
			0, 0, -1, 1'b0, NO_REPORT},
		'{LAY_JP2, 0, 1, 32'd9, JL_EXACT, 16'd41, 32'd8, 32'd8, 16'd1, 11,
			45, 0, 30, 1'b1, ERROR_REPORT}
	};

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	jhs_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	jhs_pkg::out_t out_data;

	// Scanner state as the predictor tracks it
	jhs_pkg::phase_t        scan_phase;
	logic [COUNT_WIDTH-1:0] scan_pos;
	logic [31:0]            box_left;
	logic [63:0]            byte_window;
	logic [15:0]            comps_due;
	logic [23:0]            depth_total;
	logic [31:0]            grid_width;
	logic [31:0]            grid_height;
	jhs_pkg::verdict_t      scan_verdict;
	logic [1:0]             triple_idx;

	logic [7:0]    buffer_bytes[$];
	jhs_pkg::out_t awaited_reports[$];
	jhs_pkg::out_t want_report;
	int            failures;
	int            send_idle_pct;
	int            stall_pct;

	jpeg2000_header_scanner_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Clock: period 10
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_scan_state();
		scan_phase = jhs_pkg::PH_SIG;
		scan_pos = '0;
		box_left = '0;
		byte_window = '0;
		comps_due = '0;
		depth_total = '0;
		grid_width = '0;
		grid_height = '0;
		scan_verdict = jhs_pkg::V_UNDECIDED;
		triple_idx = '0;
	endfunction

	function automatic void bump_pos();
		if (scan_pos != '1) begin
			scan_pos = scan_pos + 1'b1;
		end
	endfunction

	function automatic void settle(input jhs_pkg::verdict_t v);
		scan_verdict = v;
		scan_phase = jhs_pkg::PH_DONE;
	endfunction

	// Pick the idling phase for the next buffer: none, sender, receiver, both
	function automatic void set_idling(input int k);
		case (k % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 52;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 52;
			end
			default: begin
				send_idle_pct = 18;
				stall_pct = 18;
			end
		endcase
	endfunction

	// Advance the predicted scanner by one byte; on the end mark, form the status word
	function automatic void scan_byte(input logic [7:0] b, input logic eob,
			output logic done, output jhs_pkg::out_t rep);
		logic [31:0] low32;
		logic [31:0] len;
		byte_window = {byte_window[55:0], b};
		low32 = byte_window[31:0];
		case (scan_phase)
			jhs_pkg::PH_SIG: begin
				if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END)) begin
					if (low32 == jhs_pkg::J2K_MAGIC) begin
						scan_phase = jhs_pkg::PH_CSHDR;
						box_left = '0;
						scan_pos = COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END + 1);
					end else if (low32 != jhs_pkg::SIG_HEAD) begin
						settle(jhs_pkg::V_NOTJP2);
					end else begin
						bump_pos();
					end
				end else if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_SIG_END)) begin
					if (byte_window == jhs_pkg::SIG_TAIL) begin
						scan_phase = jhs_pkg::PH_BOXHDR;
						scan_pos = '0;
					end else begin
						settle(jhs_pkg::V_NOTJP2);
					end
				end else begin
					bump_pos();
				end
			end
			jhs_pkg::PH_BOXHDR: begin
				if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_BOXHDR_END)) begin
					len = byte_window[63:32];
					scan_pos = '0;
					if (low32 == jhs_pkg::TYPE_JP2C) begin
						box_left = (len > jhs_pkg::BOX_HDR_LEN) ?
							len - jhs_pkg::BOX_HDR_LEN : '0;
						scan_phase = jhs_pkg::PH_CSHDR;
					end else if (len < jhs_pkg::BOX_HDR_LEN) begin
						settle(jhs_pkg::V_ERROR);
					end else begin
						box_left = len - jhs_pkg::BOX_HDR_LEN;
						scan_phase = (box_left != 0) ? jhs_pkg::PH_SKIP : jhs_pkg::PH_BOXHDR;
					end
				end else begin
					bump_pos();
				end
			end
			jhs_pkg::PH_SKIP: begin
				if (box_left != 0) begin
					box_left = box_left - 1'b1;
				end
				if (box_left == 0) begin
					scan_phase = jhs_pkg::PH_BOXHDR;
					scan_pos = '0;
				end
			end
			jhs_pkg::PH_CSHDR: begin
				if (box_left != 0) begin
					box_left = box_left - 1'b1;
				end
				if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_MAGIC_END) &&
						low32 != jhs_pkg::J2K_MAGIC) begin
					settle(jhs_pkg::V_ERROR);
				end else if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_LSIZ_END) &&
						low32[15:0] < jhs_pkg::SIZ_MIN_LEN) begin
					settle(jhs_pkg::V_ERROR);
				end else begin
					if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_WIDTH_END)) begin
						grid_width = low32;
					end
					if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_HEIGHT_END)) begin
						grid_height = low32;
					end
					if (scan_pos == COUNT_WIDTH'(jhs_pkg::POS_SIZ_LAST)) begin
						comps_due = low32[15:0];
						depth_total = '0;
						triple_idx = '0;
						scan_phase = jhs_pkg::PH_COMP;
					end
					bump_pos();
				end
			end
			jhs_pkg::PH_COMP: begin
				if (box_left != 0) begin
					box_left = box_left - 1'b1;
				end
				// first byte of each component triple is its depth
				if (comps_due != 0) begin
					if (triple_idx == 0) begin
						depth_total = depth_total + 24'(b) + 24'd1;
					end
					if (triple_idx == 2'd2) begin
						triple_idx = '0;
						comps_due = comps_due - 1'b1;
					end else begin
						triple_idx = triple_idx + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		done = eob;
		rep = '0;
		if (eob) begin
			if (scan_verdict == jhs_pkg::V_NOTJP2 ||
					(scan_verdict == jhs_pkg::V_UNDECIDED &&
					scan_phase == jhs_pkg::PH_SIG)) begin
				rep.status = jhs_pkg::ST_NOTJP2;
			end else if (scan_verdict == jhs_pkg::V_UNDECIDED &&
					scan_phase == jhs_pkg::PH_COMP &&
					comps_due == 0 && box_left == 0) begin
				rep = '{jhs_pkg::ST_OK, grid_width, grid_height, depth_total};
			end else begin
				rep.status = jhs_pkg::ST_ERROR;
			end
			clear_scan_state();
		end
	endfunction

	function automatic void push_word(input logic [31:0] w);
		buffer_bytes.push_back(w[31:24]);
		buffer_bytes.push_back(w[23:16]);
		buffer_bytes.push_back(w[15:8]);
		buffer_bytes.push_back(w[7:0]);
	endfunction

	function automatic void push_noise(input int n);
		repeat (n) buffer_bytes.push_back(8'($urandom));
	endfunction

	// Lay out one buffer from its recipe, then trim and corrupt as asked
	function automatic void build_buffer(input buffer_plan_t p);
		int          sent;
		int          c;
		logic [31:0] len;
		buffer_bytes.delete();
		sent = (p.csiz <= 16) ? int'(p.csiz) : 2;
		if (p.layout == LAY_NOISE) begin
			push_noise(p.noise_len);
		end else begin
			if (p.layout == LAY_JP2) begin
				push_word(jhs_pkg::SIG_HEAD);
				push_word(jhs_pkg::SIG_TAIL[63:32]);
				push_word(jhs_pkg::SIG_TAIL[31:0]);
				// skip boxes get a type with the top bit set, never jp2c
				repeat (p.boxes) begin
					push_word(p.box_len);
					push_word($urandom | 32'h8000_0000);
					if (p.box_len >= jhs_pkg::BOX_HDR_LEN && p.box_len <= 32'd64) begin
						push_noise(int'(p.box_len - jhs_pkg::BOX_HDR_LEN));
					end else begin
						push_noise(3);
					end
				end
				if (p.jlen != JL_NONE) begin
					case (p.jlen)
						JL_ZERO:  len = '0;
						JL_TINY:  len = 32'($urandom_range(1, 8));
						JL_EXACT: len = jhs_pkg::BOX_HDR_LEN +
							32'(CS_HEAD_BYTES + 3 * sent + p.extra);
						default:  len = '1;
					endcase
					push_word(len);
					push_word(jhs_pkg::TYPE_JP2C);
				end
			end
			if (p.layout == LAY_RAW || p.jlen != JL_NONE) begin
				push_word(jhs_pkg::J2K_MAGIC);
				buffer_bytes.push_back(p.lsiz[15:8]);
				buffer_bytes.push_back(p.lsiz[7:0]);
				push_noise(2);
				push_word(p.width);
				push_word(p.height);
				push_noise(24);
				buffer_bytes.push_back(p.csiz[15:8]);
				buffer_bytes.push_back(p.csiz[7:0]);
				for (c = 0; c < sent; c++) begin
					buffer_bytes.push_back((p.depth < 0) ? 8'($urandom) : p.depth[7:0]);
					push_noise(2);
				end
				push_noise(p.extra);
			end
		end
		repeat (p.cut) begin
			if (buffer_bytes.size() > 1) begin
				void'(buffer_bytes.pop_back());
			end
		end
		if (p.corrupt_at >= 0 && p.corrupt_at < buffer_bytes.size()) begin
			buffer_bytes[p.corrupt_at] = buffer_bytes[p.corrupt_at] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	function automatic logic [31:0] grid_value();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	// Mostly well-formed buffers with random content; some truncated or corrupted
	function automatic buffer_plan_t random_plan();
		buffer_plan_t p;
		int           pick;
		p = '0;
		p.depth = -1;
		p.corrupt_at = -1;
		pick = $urandom_range(99);
		p.layout = (pick < 8) ? LAY_NOISE : (pick < 45) ? LAY_RAW : LAY_JP2;
		p.noise_len = $urandom_range(1, 16);
		p.boxes = $urandom_range(0, 2);
		if ($urandom_range(19) == 0) begin
			p.box_len = 32'($urandom_range(0, 7));
		end else begin
			p.box_len = 32'($urandom_range(8, 24));
		end
		pick = $urandom_range(19);
		if (pick == 0) begin
			p.jlen = JL_NONE;
		end else if (pick == 1) begin
			p.jlen = JL_HUGE;
		end else if (pick < 8) begin
			p.jlen = JL_ZERO;
		end else if (pick < 11) begin
			p.jlen = JL_TINY;
		end else begin
			p.jlen = JL_EXACT;
		end
		pick = $urandom_range(29);
		if (pick == 0) begin
			p.csiz = 16'hffff;
		end else if (pick == 1) begin
			p.csiz = 16'($urandom);
		end else begin
			p.csiz = 16'($urandom_range(0, 4));
		end
		if ($urandom_range(14) == 0) begin
			p.lsiz = 16'($urandom_range(0, 40));
		end else begin
			p.lsiz = jhs_pkg::SIZ_MIN_LEN + 16'd3 * p.csiz;
		end
		p.width = grid_value();
		p.height = grid_value();
		p.cut = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 0;
		p.extra = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
		if ($urandom_range(14) == 0) begin
			p.corrupt_at = $urandom_range(0, 40);
		end
		return p;
	endfunction

	// Send the built buffer word by word, predicting each status word on acceptance
	task automatic send_buffer(input logic typed, input jhs_pkg::out_t typed_rep);
		logic          done;
		logic          eob;
		jhs_pkg::out_t rep;
		foreach (buffer_bytes[i]) begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			eob = (i == buffer_bytes.size() - 1);
			in_valid <= 1'b1;
			in_data <= '{buffer_bytes[i], eob};
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			scan_byte(in_data.data_byte, in_data.end_of_buffer, done, rep);
			if (done) begin
				awaited_reports.push_back(typed ? typed_rep : rep);
			end
			@(negedge clk);
		end
	endtask

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check each accepted status word against the oldest awaited one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$error("status word accepted with none awaited");
				failures++;
			end else begin
				want_report = awaited_reports.pop_front();
				if (out_data.status !== want_report.status) begin
					$error("status: expected %0d, got %0d", want_report.status, out_data.status);
					failures++;
				end
				if (out_data.image_width !== want_report.image_width) begin
					$error("image_width: expected %0h, got %0h",
						want_report.image_width, out_data.image_width);
					failures++;
				end
				if (out_data.image_height !== want_report.image_height) begin
					$error("image_height: expected %0h, got %0h",
						want_report.image_height, out_data.image_height);
					failures++;
				end
				if (out_data.total_depth !== want_report.total_depth) begin
					$error("total_depth: expected %0d, got %0d",
						want_report.total_depth, out_data.total_depth);
					failures++;
				end
			end
		end
	end

	// Abort when no word moves on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Main sequence: reset, directed buffers, then random buffers; idling rotates per buffer
	initial begin
		int           n;
		int           buf_idx;
		buffer_plan_t plan;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		failures = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		buf_idx = 0;
		clear_scan_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < NUM_DIRECTED; n++) begin
			set_idling(buf_idx);
			buf_idx++;
			build_buffer(DIRECTED_BUFFERS[n]);
			send_buffer(DIRECTED_BUFFERS[n].typed, DIRECTED_BUFFERS[n].report);
		end

		for (n = 0; n < RANDOM_BUFFERS; n++) begin
			set_idling(buf_idx);
			buf_idx++;
			plan = random_plan();
			build_buffer(plan);
			send_buffer(1'b0, NO_REPORT);
		end

		// Drain the awaited status words, then let the clock run on before the verdict
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
